// ----- design/fdsw_pkg.sv -----
// Shared constants and helper functions for the four-digit segment display writer.
// No dependencies.
package fdsw_pkg;

  localparam int VALUE_W = 14;
  localparam int BYTE_W  = 8;
  localparam int DIGIT_W = 4;

  localparam logic [BYTE_W-1:0] CMD_DATA_WRITE = 8'h40;
  localparam logic [BYTE_W-1:0] CMD_ADDRESS    = 8'hC0;

  // floor(v / 10) == (v * RECIP_10) >> RECIP_SHIFT for all v < 43699
  localparam logic [15:0] RECIP_10    = 16'd52429;
  localparam int          RECIP_SHIFT = 19;
  localparam int          PROD_W      = VALUE_W + 16;

  typedef struct packed {
    logic [VALUE_W-1:0] quot;
    logic [DIGIT_W-1:0] digit;
  } divmod_t;

  function automatic divmod_t divmod10(input logic [VALUE_W-1:0] v);
    logic [PROD_W-1:0]  prod;
    logic [VALUE_W-1:0] q;
    logic [VALUE_W-1:0] q10;
    logic [VALUE_W-1:0] rem;
    divmod_t            res;
    prod      = PROD_W'(v) * PROD_W'(RECIP_10);
    q         = VALUE_W'(prod[PROD_W-1:RECIP_SHIFT]);
    q10       = {q[VALUE_W-4:0], 3'b000} + {q[VALUE_W-2:0], 1'b0};
    rem       = v - q10;
    res.quot  = q;
    res.digit = rem[DIGIT_W-1:0];
    return res;
  endfunction

  function automatic logic [BYTE_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
    logic [BYTE_W-1:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// ----- design/fdsw_in_if.sv -----
// Input channel: one value word per handshake.
// Depends on fdsw_pkg.
interface fdsw_in_if;
  logic                         valid;
  logic                         ready;
  logic [fdsw_pkg::VALUE_W-1:0] value;

  modport source(output valid, output value, input ready);
  modport sink(input valid, input value, output ready);
endinterface

// ----- design/fdsw_out_if.sv -----
// Result channel: one controller byte word per handshake, with framing flags.
// Depends on fdsw_pkg.
interface fdsw_out_if;
  logic                        valid;
  logic                        ready;
  logic [fdsw_pkg::BYTE_W-1:0] wire_byte;
  logic                        start_before;
  logic                        stop_after;
  logic                        last;

  modport source(output valid, output wire_byte, output start_before,
                 output stop_after, output last, input ready);
  modport sink(input valid, input wire_byte, input start_before,
               input stop_after, input last, output ready);
endinterface

// ----- design/four_digit_segment_display_writer_unit.sv -----
// Top level of the four-digit segment display writer.
// Depends on fdsw_pkg, fdsw_in_if, fdsw_out_if, fdsw_digit_pipe, fdsw_byte_ser.
//
// Usage:
//   in_if  carries one value word (14 bits); the low DIGIT_COUNT decimal digits
//          are shown, leading zeros as the pattern for 0.
//   out_if carries DIGIT_COUNT+2 byte words per value: 0x40 (start and stop),
//          0xC0 (start), then the segment patterns most significant digit
//          first, the final one with stop_after and last set.
//   Path: a value passes the input register, one stage per digit, then the
//          byte register of the sequencer before its first byte is offered.
//          Throughput: one byte per cycle while out_if.ready is high, with no
//          gap between values when the next one is waiting, set by the byte sequencer.
//   The digit pipeline keeps taking values while the sequencer is busy, so up
//   to DIGIT_COUNT+1 values can be in flight behind the one being sent.
//   When out_if.ready is low the current byte holds and the pipeline fills,
//   then in_if.ready drops. Synchronous reset (rst_n low) empties every stage
//   and the sequencer; nothing else needs clearing.
module four_digit_segment_display_writer_unit #(
  parameter int DIGIT_COUNT = 4
) (
  input logic        clk,
  input logic        rst_n,
  fdsw_in_if.sink    in_if,
  fdsw_out_if.source out_if
);
  import fdsw_pkg::*;

  logic                               dig_valid;
  logic                               dig_ready;
  logic [DIGIT_COUNT-1:0][BYTE_W-1:0] dig_seg;

  fdsw_digit_pipe #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_digit_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_value  (in_if.value),
    .dig_valid (dig_valid),
    .dig_ready (dig_ready),
    .dig_seg   (dig_seg)
  );

  fdsw_byte_ser #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_byte_ser (
    .clk              (clk),
    .rst_n            (rst_n),
    .dig_valid        (dig_valid),
    .dig_ready        (dig_ready),
    .dig_seg          (dig_seg),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_wire_byte    (out_if.wire_byte),
    .out_start_before (out_if.start_before),
    .out_stop_after   (out_if.stop_after),
    .out_last         (out_if.last)
  );

endmodule

// ----- design/fdsw_digit_pipe.sv -----
// Input register plus one pipeline stage per decimal digit; each stage peels
// off one digit and maps it to a segment pattern. Depends on fdsw_pkg.
module fdsw_digit_pipe #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic [fdsw_pkg::VALUE_W-1:0]                  in_value,
  output logic                                          dig_valid,
  input  logic                                          dig_ready,
  output logic [DIGIT_COUNT-1:0][fdsw_pkg::BYTE_W-1:0] dig_seg
);
  import fdsw_pkg::*;

  logic                               vld_r [0:DIGIT_COUNT];
  logic [VALUE_W-1:0]                 val_r [0:DIGIT_COUNT];
  logic [DIGIT_COUNT-1:0][BYTE_W-1:0] seg_r [1:DIGIT_COUNT];
  logic                               rdy   [0:DIGIT_COUNT+1];

  assign rdy[DIGIT_COUNT+1] = dig_ready;

  genvar k;
  generate
    for (k = 0; k <= DIGIT_COUNT; k++) begin : g_rdy
      assign rdy[k] = !vld_r[k] || rdy[k+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld_r[0] <= in_valid;
    end
    if (rdy[0] && in_valid) begin
      val_r[0] <= in_value;
    end
  end

  generate
    for (k = 1; k <= DIGIT_COUNT; k++) begin : g_stage
      divmod_t                            dm;
      logic [DIGIT_COUNT-1:0][BYTE_W-1:0] seg_nxt;

      assign dm = divmod10(val_r[k-1]);

      if (k == 1) begin : g_first
        always_comb begin
          seg_nxt      = '0;
          seg_nxt[k-1] = seg_of(dm.digit);
        end
      end else begin : g_rest
        always_comb begin
          seg_nxt      = seg_r[k-1];
          seg_nxt[k-1] = seg_of(dm.digit);
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
        if (rdy[k] && vld_r[k-1]) begin
          val_r[k] <= dm.quot;
          seg_r[k] <= seg_nxt;
        end
      end
    end
  endgenerate

  assign in_ready  = rdy[0];
  assign dig_valid = vld_r[DIGIT_COUNT];
  assign dig_seg   = seg_r[DIGIT_COUNT];

  // final stage quotient is dropped: digits above DIGIT_COUNT are not shown
  logic unused_quot;
  assign unused_quot = ^val_r[DIGIT_COUNT];

endmodule

// ----- design/fdsw_byte_ser.sv -----
// Holds one value's segment patterns and walks the controller byte sequence,
// one word per handshake. Depends on fdsw_pkg.
module fdsw_byte_ser #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          dig_valid,
  output logic                                          dig_ready,
  input  logic [DIGIT_COUNT-1:0][fdsw_pkg::BYTE_W-1:0] dig_seg,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [fdsw_pkg::BYTE_W-1:0]                   out_wire_byte,
  output logic                                          out_start_before,
  output logic                                          out_stop_after,
  output logic                                          out_last
);
  import fdsw_pkg::*;

  localparam int          IDX_W    = $clog2(DIGIT_COUNT + 2);
  localparam logic [IDX_W-1:0] IDX_CMD  = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_ADDR = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIGIT_COUNT + 1);

  logic                               busy_r, busy_nxt;
  logic [IDX_W-1:0]                   cnt_r, cnt_nxt;
  logic [DIGIT_COUNT-1:0][BYTE_W-1:0] seg_r;
  logic                               at_last;
  logic                               take;
  logic [BYTE_W-1:0]                  seg_sel;

  assign at_last   = (cnt_r == IDX_LAST);
  assign dig_ready = !busy_r || (out_ready && at_last);
  assign take      = dig_valid && dig_ready;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (busy_r && out_ready) begin
      if (at_last) begin
        busy_nxt = 1'b0;
        cnt_nxt  = IDX_CMD;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    if (take) begin
      busy_nxt = 1'b1;
      cnt_nxt  = IDX_CMD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= IDX_CMD;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (take) begin
      seg_r <= dig_seg;
    end
  end

  // most significant digit goes first
  always_comb begin
    seg_sel = '0;
    for (int j = 0; j < DIGIT_COUNT; j++) begin
      if (cnt_r == IDX_W'(DIGIT_COUNT + 1 - j)) seg_sel = seg_r[j];
    end
  end

  always_comb begin
    out_start_before = 1'b0;
    out_stop_after   = at_last;
    case (cnt_r)
      IDX_CMD: begin
        out_wire_byte    = CMD_DATA_WRITE;
        out_start_before = 1'b1;
        out_stop_after   = 1'b1;
      end
      IDX_ADDR: begin
        out_wire_byte    = CMD_ADDRESS;
        out_start_before = 1'b1;
      end
      default: begin
        out_wire_byte = seg_sel;
      end
    endcase
  end

  assign out_valid = busy_r;
  assign out_last  = at_last;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r <= IDX_LAST)
    else $error("byte index past end of sequence");

  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == IDX_CMD)
    else $error("idle with nonzero byte index");

  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && out_ready && !at_last) |=> busy_r && cnt_r == $past(cnt_r) + 1'b1)
    else $error("byte index did not advance");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !out_ready) |=> busy_r && $stable(cnt_r) && $stable(seg_r))
    else $error("sequence changed while stalled");

  a_no_early_load: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !at_last) |-> !dig_ready)
    else $error("new value taken mid-sequence");

endmodule

// ----- sim/four_digit_segment_display_writer_unit_tb.sv -----
// Testbench for four_digit_segment_display_writer_unit: drives value words, predicts
// the six controller bytes per value and checks every result word in order.
// Depends on fdsw_pkg, fdsw_in_if, fdsw_out_if and the unit itself.
`timescale 1ns / 1ps

module four_digit_segment_display_writer_unit_tb;
  import fdsw_pkg::*;

  localparam int DIGITS      = 4;
  localparam int STALL_LIMIT = 3000;

  // segment patterns indexed by decimal digit
  localparam logic [9:0][BYTE_W-1:0] SEG_PATTERN = {
    8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  typedef enum logic [0:0] {SINK_ALWAYS, SINK_RANDOM} sink_mode_t;

  typedef struct packed {
    logic [BYTE_W-1:0] wire_byte;
    logic              start_before;
    logic              stop_after;
    logic              last;
  } frame_word_t;

  logic clk = 1'b0;
  logic rst_n;

  fdsw_in_if  in_if ();
  fdsw_out_if out_if ();

  four_digit_segment_display_writer_unit #(.DIGIT_COUNT(DIGITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always #5 clk = ~clk;

  frame_word_t due_words[$];
  int          mismatches    = 0;
  int          words_checked = 0;
  int          values_taken  = 0;
  int          stall_cycles  = 0;
  int          sink_hold     = 0;
  sink_mode_t  sink_mode     = SINK_ALWAYS;
  bit          src_idle      = 1'b0;

  function automatic void queue_display_frame(input logic [VALUE_W-1:0] v);
    int unsigned rest;
    int          i;
    logic [3:0]  dig [DIGITS];
    frame_word_t w;
    rest = 32'(v);
    for (i = 0; i < DIGITS; i++) begin
      dig[i] = 4'(rest % 10);
      rest   = rest / 10;
    end
    due_words.push_back('{CMD_DATA_WRITE, 1'b1, 1'b1, 1'b0});
    due_words.push_back('{CMD_ADDRESS, 1'b1, 1'b0, 1'b0});
    for (i = DIGITS - 1; i >= 0; i--) begin
      w.wire_byte    = SEG_PATTERN[dig[i]];
      w.start_before = 1'b0;
      w.stop_after   = (i == 0);
      w.last         = (i == 0);
      due_words.push_back(w);
    end
  endfunction

  function automatic void note_mismatch(input string what, input frame_word_t want,
                                        input frame_word_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s at word %0d: want byte %02h start %b stop %b last %b",
               what, words_checked, want.wire_byte, want.start_before,
               want.stop_after, want.last);
      $display("  got byte %02h start %b stop %b last %b",
               got.wire_byte, got.start_before, got.stop_after, got.last);
    end
  endfunction

  // 1..3 mostly, now and then a long stretch
  function automatic int draw_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return VALUE_W'($urandom_range(0, 9999));
    if (r < 92) return VALUE_W'($urandom_range(10000, 16383));
    return VALUE_W'($urandom_range(0, 9) * 1111);
  endfunction

  always @(posedge clk) begin : scoreboard
    frame_word_t got;
    frame_word_t want;
    bit          moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        queue_display_frame(in_if.value);
        values_taken++;
        moved = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.wire_byte, out_if.start_before, out_if.stop_after, out_if.last};
        moved = 1'b1;
        if (due_words.size() == 0) begin
          note_mismatch("unexpected word", '0, got);
        end else begin
          want = due_words.pop_front();
          if (got !== want) note_mismatch("mismatch", want, got);
        end
        words_checked++;
      end
    end
    stall_cycles = moved ? 0 : stall_cycles + 1;
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : sink_side
    int gap_left;
    gap_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        sink_hold--;
        out_if.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_if.ready <= 1'b0;
      end else if (sink_mode == SINK_RANDOM && $urandom_range(0, 3) == 0) begin
        gap_left = draw_gap() - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // valid stays high after a word so back-to-back values need no extra edge
  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    gap = (src_idle && $urandom_range(0, 1)) ? draw_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // wait on the clock first so the last accepted value is already queued
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (due_words.size() != 0) @(posedge clk);
    repeat (DIGITS + 4) @(posedge clk);
  endtask

  task automatic test_corner_values();
    int corner [18] = '{0, 9999, 16383, 10000, 1, 7, 42, 305, 1000, 1234, 5678,
                        9012, 8888, 4096, 8192, 12345, 9990, 10};
    int i;
    sink_mode = SINK_ALWAYS;
    src_idle  = 1'b0;
    for (i = 0; i < 18; i++) send_value(VALUE_W'(corner[i]));
    sink_mode = SINK_RANDOM;
    src_idle  = 1'b1;
    send_value('0);
    send_value(VALUE_W'(16383));
  endtask

  task automatic test_random_values();
    int i;
    for (i = 0; i < 82; i++) begin
      // middle stretch runs with no idling on either side
      sink_mode = (i >= 40 && i < 60) ? SINK_ALWAYS : SINK_RANDOM;
      src_idle  = !(i >= 40 && i < 60);
      send_value(pick_value());
    end
  endtask

  task automatic test_full_backpressure();
    int i;
    src_idle  = 1'b0;
    sink_hold = 120;
    for (i = 0; i < 12; i++) send_value(pick_value());
    src_idle = 1'b1;
  endtask

  task automatic test_pause_until_drained();
    int i;
    wait_drained();
    for (i = 0; i < 6; i++) send_value(pick_value());
  endtask

  initial begin : main
    rst_n       <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.value <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_values();
    test_random_values();
    test_full_backpressure();
    test_pause_until_drained();
    wait_drained();

    if (due_words.size() != 0) begin
      mismatches++;
      $display("%0d expected words never arrived", due_words.size());
    end
    $display("Sent %0d values (corners, above-range, random, full stall, drain pause)",
             values_taken);
    $display("Checked %0d display words, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/fdsw_pkg.sv
design/fdsw_in_if.sv
design/fdsw_out_if.sv
design/fdsw_digit_pipe.sv
design/fdsw_byte_ser.sv
design/four_digit_segment_display_writer_unit.sv
sim/four_digit_segment_display_writer_unit_tb.sv
